### rtl/zrt_pkg.sv
// ----------------------------------------------------------------------------
// zrt_pkg
// Shared sizes, types and state codes for the zigzag rail transposer.
// ----------------------------------------------------------------------------
package zrt_pkg;

  localparam int MAX_LEN = 64;                    // message buffer depth
  localparam int ADDR_W  = $clog2(MAX_LEN);       // buffer address
  localparam int CNT_W   = $clog2(MAX_LEN + 1);   // byte count 0..MAX_LEN
  localparam int POS_W   = CNT_W + 1;             // zigzag slot, below 3*MAX_LEN
  localparam int RAIL_W  = 7;                     // rail_count register
  localparam int BYTE_W  = 8;

  localparam logic [RAIL_W-1:0] RAIL_RESET = RAIL_W'(3);

  typedef enum logic {
    ST_IN,   // collecting message bytes
    ST_OUT   // gathering the transposed message
  } zrt_state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic              issue;  // read the buffer this cycle
    logic [ADDR_W-1:0] addr;   // entry to read
    logic              last;   // this read is the final byte
    logic              busy;   // gather pass in progress
  } zrt_gen_t;

endpackage

### rtl/zrt_order_gen.sv
// ----------------------------------------------------------------------------
// zrt_order_gen
// Walks the zigzag slots rail by rail and issues buffer reads in output order.
// ----------------------------------------------------------------------------
module zrt_order_gen import zrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,     // begin a pass over n bytes
  input  logic [CNT_W-1:0]  n,
  input  logic [RAIL_W-1:0] rails,
  input  logic              step_en,   // output side can take a read
  output zrt_gen_t          gen
);

  logic              busy;
  logic [RAIL_W-1:0] row;
  logic [POS_W-1:0]  base;
  logic              phase;   // 0: down stroke slot, 1: up stroke slot
  logic [CNT_W-1:0]  issued;
  logic [CNT_W-1:0]  n_r;

  logic [RAIL_W-1:0] rails_eff;
  logic [RAIL_W:0]   period_full;
  logic [POS_W-1:0]  period;
  logic [POS_W-1:0]  step;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  base_adv;
  logic              pass;
  logic              middle;
  logic              hit;
  logic              last;

  always_comb begin
    rails_eff   = (rails == '0) ? RAIL_W'(1) : rails;
    pass        = (rails_eff == RAIL_W'(1)) || (POS_W'(n_r) <= POS_W'(rails_eff));
    period_full = {rails_eff, 1'b0} - (RAIL_W+1)'(2);
    period      = POS_W'(period_full);
    step        = pass ? POS_W'(1) : period;
    middle      = !pass && (row != '0) && (row != rails_eff - RAIL_W'(1));
    pos         = phase ? (base + period - POS_W'(row)) : (base + POS_W'(row));
    base_adv    = base + step;
    hit         = busy && step_en && (pos < POS_W'(n_r));
    last        = (issued == n_r - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      row    <= '0;
      base   <= '0;
      phase  <= 1'b0;
      issued <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      row    <= '0;
      base   <= '0;
      phase  <= 1'b0;
      issued <= '0;
    end else if (busy && step_en) begin
      if (hit) begin
        issued <= issued + CNT_W'(1);
        if (last) busy <= 1'b0;
      end
      if (!phase && middle) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        if (base_adv >= POS_W'(n_r)) begin
          row  <= row + RAIL_W'(1);
          base <= '0;
        end else begin
          base <= base_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) n_r <= n;
  end

  always_comb begin
    gen.issue = hit;
    gen.addr  = pos[ADDR_W-1:0];
    gen.last  = last;
    gen.busy  = busy;
  end

endmodule

### rtl/zigzag_rail_transpose_top.sv
// ----------------------------------------------------------------------------
// zigzag_rail_transpose_top
// Rail fence transposition of a byte message held in an on-chip buffer.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents                     handshake
//  s_*       in   tdata[7:0] in_byte, tlast in_last  tvalid/tready
//  m_*       out  tdata[7:0] out_byte, tlast out_last tvalid/tready
//  cfg_*     in   cfg_wdata[6:0] rail_count          cfg_we, no back-pressure
//
//  Input beats are taken one per cycle into the buffer while collecting.
//  The last-marked beat closes the message; input then stalls while the
//  sequencer walks the zigzag slots, one slot per cycle while the output
//  is not stalled. A slot past the end of the message yields no beat.
//  The buffer read is registered straight into the output register.
//  Reset: rail_count 3, buffer empty; the buffer itself is not cleared.
//  Output stalls simply hold the sequencer; no beat is lost.
// ----------------------------------------------------------------------------
module zigzag_rail_transpose_top import zrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] in_byte
  input  logic              s_tlast,   // in_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,   // out_last
  input  logic              cfg_we,
  input  logic [RAIL_W-1:0] cfg_wdata  // rail_count
);

  // message buffer
  logic [BYTE_W-1:0] mem [MAX_LEN];

  zrt_state_t        state, state_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_after;
  logic [RAIL_W-1:0] rail_count;
  logic [BYTE_W-1:0] rd_data;
  logic              out_valid;
  logic              out_last;
  logic              in_beat;
  logic              start;
  logic              step_en;
  zrt_gen_t          gen;

  assign in_beat    = s_tvalid && s_tready;
  assign start      = in_beat && s_tlast;
  assign fill_after = (fill < CNT_W'(MAX_LEN)) ? fill + CNT_W'(1) : fill;
  assign step_en    = !out_valid || m_tready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) rail_count <= RAIL_RESET;
    else if (cfg_we) rail_count <= cfg_wdata;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IN:  if (start) state_next = ST_OUT;
      ST_OUT: if (gen.issue && gen.last) state_next = ST_IN;
      default: state_next = ST_IN;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state)
      ST_IN:   s_tready = 1'b1;
      ST_OUT:  s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (in_beat) fill <= s_tlast ? '0 : fill_after;
    end
  end

  // buffer write: bytes past the buffer size are dropped
  always_ff @(posedge clk) begin
    if (in_beat && (fill < CNT_W'(MAX_LEN))) mem[fill[ADDR_W-1:0]] <= s_tdata;
  end

  // buffer read straight into the output register
  always_ff @(posedge clk) begin
    if (gen.issue) begin
      rd_data  <= mem[gen.addr];
      out_last <= gen.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (gen.issue) out_valid <= 1'b1;
    else if (m_tready) out_valid <= 1'b0;
  end

  zrt_order_gen u_gen (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .n       (fill_after),
    .rails   (rail_count),
    .step_en (step_en),
    .gen     (gen)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = rd_data;
  assign m_tlast  = out_last;

endmodule

### rtl/zrt_checker.sv
// ----------------------------------------------------------------------------
// zrt_checker
// Port-level checks on the transposer, bound to the top level.
// ----------------------------------------------------------------------------
module zrt_checker import zrt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              s_tlast,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [7:0]        m_tdata,
  input logic              m_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed under stall");

  // closing a message stops intake while it drains
  a_close: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input open after last beat");

  // mid-message beats keep intake open
  a_open: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> s_tready)
    else $error("input closed mid-message");

  // nothing leaves straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind zigzag_rail_transpose_top zrt_checker u_zrt_checker (.*);

### dv/zigzag_rail_transpose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_rail_transpose_checker
// Watches the byte, output and rail_count channels, predicts the rail-order
// message and compares each output beat with the oldest expected one.
// ----------------------------------------------------------------------------
module zigzag_rail_transpose_checker import zrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] in_byte
  input  logic              s_tlast,   // in_last
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,   // [7:0] out_byte
  input  logic              m_tlast,   // out_last
  input  logic              cfg_we,
  input  logic [RAIL_W-1:0] cfg_wdata, // rail_count
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } rail_beat_t;

  logic [BYTE_W-1:0] msg_buf [MAX_LEN];
  int unsigned       msg_len;
  logic [RAIL_W-1:0] rails_reg;
  rail_beat_t        rail_q[$];
  rail_beat_t        want;
  int                errors = 0;

  // Gather order: as is for one rail or n <= rails; else rail by rail, each rail taking
  // the down slot and, on the inner rails, the up slot of every zigzag period.
  function automatic void queue_rail_order(input int unsigned n,
                                           input logic [RAIL_W-1:0] rails_cfg);
    int unsigned rails;
    int unsigned period;
    int unsigned p;
    rail_beat_t  order[$];
    rails = (rails_cfg == '0) ? 1 : rails_cfg;
    if (rails == 1 || n <= rails) begin
      for (int unsigned i = 0; i < n; i++)
        order.push_back('{msg_buf[i], 1'b0});
    end else begin
      period = 2 * rails - 2;
      for (int unsigned row = 0; row < rails; row++) begin
        for (int unsigned base = 0; base < n; base += period) begin
          p = base + row;
          if (p < n) order.push_back('{msg_buf[p], 1'b0});
          if (row != 0 && row != rails - 1) begin
            p = base + period - row;
            if (p < n) order.push_back('{msg_buf[p], 1'b0});
          end
        end
      end
    end
    order[order.size() - 1].last = 1'b1;
    foreach (order[i]) rail_q.push_back(order[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      msg_len   = 0;
      rails_reg = RAIL_RESET;
      rail_q.delete();
    end else begin
      if (cfg_we) rails_reg = cfg_wdata;

      if (m_tvalid && m_tready) begin
        if (rail_q.size() == 0) begin
          $display("%0t: output beat with none expected, actual byte %02h last %0b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = rail_q.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, m_tlast);
            errors++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        // bytes past a full buffer are dropped, but a last mark still closes
        if (msg_len < MAX_LEN) begin
          msg_buf[msg_len] = s_tdata;
          msg_len++;
        end
        if (s_tlast) begin
          queue_rail_order(msg_len, rails_reg);
          msg_len = 0;
        end
      end
    end
    fail_count <= errors;
    pending    <= rail_q.size();
  end

endmodule

### dv/zigzag_rail_transpose_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_rail_transpose_top_tb
// Drives byte messages through the rail fence transposer under bursty input
// and output back-pressure, with rail_count swept between messages.
// ----------------------------------------------------------------------------
module zigzag_rail_transpose_top_tb;
  import zrt_pkg::*;

  localparam int RAND_BEATS = 86;          // rough size of the random part
  localparam int SETTLE_CYC = 2 * MAX_LEN; // sequencer tail after last beat

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;       // [7:0] in_byte
  logic              s_tlast   = 1'b0;     // in_last
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [7:0]        m_tdata;              // [7:0] out_byte
  logic              m_tlast;              // out_last
  logic              cfg_we    = 1'b0;
  logic [RAIL_W-1:0] cfg_wdata = '0;       // rail_count

  int                fail_count;
  int                pending;

  // sender pacing
  logic              steady     = 1'b0;    // no gaps for the current message
  int                burst_left = 4;
  int                rand_beats = 0;
  int                msg_idx    = 0;
  int                msg_n;
  logic [RAIL_W-1:0] rails_pick;

  // receiver stall pattern
  logic [9:0]        stall_cyc  = '0;

  logic [7:0] corner_bytes [7] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7E};

  zigzag_rail_transpose_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  zigzag_rail_transpose_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: the mode moves on in turn - always ready, coin toss,
  // one stall in five, mostly ready. Gaps land on every phase of the drain.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[8:7])
      2'd0: begin
        m_tready <= 1'b1;
      end
      2'd1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        m_tready <= (stall_cyc % 5) != 0;
      end
      default: begin
        m_tready <= $urandom_range(0, 3) != 0;
      end
    endcase
  end

  // One input beat. Handshake is judged on values from before the edge.
  // Unless the message runs steady, a burst ends with a gap.
  task automatic send_byte(input logic [7:0] b, input logic l);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Hold input until every predicted beat has come out. The first edge lets
  // the checker see a last beat accepted just before.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // rail_count only changes with the block idle and its sequencer settled
  task automatic set_rails(input logic [RAIL_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---------------------------------------------------------
    // reset rail_count (3): lone last-marked byte, then a zigzag of corners
    send_byte(8'h5A, 1'b1);
    foreach (corner_bytes[i])
      send_byte(corner_bytes[i], i == 6);
    set_rails(RAIL_W'(1));   // single rail passes straight through
    send_message(4);
    set_rails('0);           // zero rails behaves as one
    send_message(3);
    set_rails(RAIL_W'(2));   // no inner rails
    send_message(5);
    set_rails(RAIL_W'(64));  // message no longer than the rail count
    send_message(4);

    // --- random -----------------------------------------------------------
    while (rand_beats < RAND_BEATS) begin
      if (msg_idx == 0) begin
        // overfull message: the tail is dropped, its last mark still closes
        set_rails(RAIL_W'($urandom_range(4, 9)));
        msg_n = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
      end else if (msg_idx == 1) begin
        set_rails(RAIL_W'(127));
        msg_n = $urandom_range(1, 16);
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 7))
            0:       rails_pick = '0;
            1:       rails_pick = RAIL_W'(1);
            2:       rails_pick = RAIL_W'(64);
            3:       rails_pick = RAIL_W'($urandom_range(65, 127));
            4:       rails_pick = RAIL_W'(63);
            default: rails_pick = RAIL_W'($urandom_range(2, 12));
          endcase
          set_rails(rails_pick);
        end
        msg_n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      end
      steady = ($urandom_range(0, 3) == 0);
      send_message(msg_n);
      rand_beats += msg_n;
      if ($urandom_range(0, 4) == 0) wait_drained();
      msg_idx++;
    end

    // --- wind down --------------------------------------------------------
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
